// ----- hdl/i86d_pkg.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// i86d_pkg
// Shared types, codes and opcode classification for the 8086 subset decoder.
// -----------------------------------------------------------------------------
package i86d_pkg;

  typedef enum logic [3:0] {
    C_BAD, C_RM_REG, C_RM_IMM, C_REG_IMM, C_ACC_MEM, C_SEG_RM, C_GRP_FF,
    C_GRP_8F, C_REG16, C_SEG, C_ACC_IMM, C_PORT, C_DXPORT, C_BARE
  } cls_t;

  typedef enum logic [5:0] {
    PH_OPC   = 6'b000001,
    PH_MODRM = 6'b000010,
    PH_DLO   = 6'b000100,
    PH_DHI   = 6'b001000,
    PH_ILO   = 6'b010000,
    PH_IHI   = 6'b100000
  } phase_t;

  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_REG  = 3'd1;
  localparam logic [2:0] K_SEG  = 3'd2;
  localparam logic [2:0] K_EA   = 3'd3;
  localparam logic [2:0] K_DIR  = 3'd4;
  localparam logic [2:0] K_IMM  = 3'd5;
  localparam logic [2:0] K_PORT = 3'd6;
  localparam logic [2:0] K_DX   = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  localparam logic [4:0] MN_MOV  = 5'd0;
  localparam logic [4:0] MN_PUSH = 5'd1;
  localparam logic [4:0] MN_POP  = 5'd2;
  localparam logic [4:0] MN_XCHG = 5'd3;
  localparam logic [4:0] MN_ADD  = 5'd4;
  localparam logic [4:0] MN_ADC  = 5'd5;
  localparam logic [4:0] MN_IN   = 5'd6;
  localparam logic [4:0] MN_OUT  = 5'd7;
  localparam logic [4:0] MN_XLAT = 5'd8;
  localparam logic [4:0] MN_LEA  = 5'd9;
  localparam logic [4:0] MN_LDS  = 5'd10;
  localparam logic [4:0] MN_LES  = 5'd11;
  localparam logic [4:0] MN_LAHF = 5'd12;
  localparam logic [4:0] MN_SAHF = 5'd13;
  localparam logic [4:0] MN_PSHF = 5'd14;
  localparam logic [4:0] MN_POPF = 5'd15;
  localparam logic [4:0] MN_AAA  = 5'd16;
  localparam logic [4:0] MN_DAA  = 5'd17;
  localparam logic [4:0] MN_AAS  = 5'd18;
  localparam logic [4:0] MN_DAS  = 5'd19;
  localparam logic [4:0] MN_CBW  = 5'd20;
  localparam logic [4:0] MN_CWD  = 5'd21;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  mnemonic;
    logic [2:0]  dest_kind;
    logic [2:0]  src_kind;
    logic [2:0]  dest_reg;
    logic [2:0]  src_reg;
    logic [1:0]  op_width;
    logic [2:0]  ea_rm;
    logic [1:0]  disp_size;
    logic [15:0] displacement;
    logic [15:0] immediate;
    logic [2:0]  inst_length;
  } rec_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       stream_end;
  } in_t;

  // Instruction as gathered so far, handed from the collector to the builder.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  opc;
    logic [7:0]  modrm;
    logic [15:0] disp;
    logic [15:0] imm;
    logic [2:0]  len;
  } gath_t;

  function automatic logic bare_known(input logic [7:0] b);
    case (b)
      8'hD7, 8'h9F, 8'h9E, 8'h9C, 8'h9D, 8'h37, 8'h27, 8'h3F, 8'h2F, 8'h98,
      8'h99: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [4:0] bare_mn(input logic [7:0] b);
    case (b)
      8'hD7: return MN_XLAT;
      8'h9F: return MN_LAHF;
      8'h9E: return MN_SAHF;
      8'h9C: return MN_PSHF;
      8'h9D: return MN_POPF;
      8'h37: return MN_AAA;
      8'h27: return MN_DAA;
      8'h3F: return MN_AAS;
      8'h2F: return MN_DAS;
      8'h98: return MN_CBW;
      8'h99: return MN_CWD;
      default: return MN_MOV;
    endcase
  endfunction

  function automatic cls_t classify(input logic [7:0] b);
    if ((b & 8'hFC) == 8'h88) return C_RM_REG;
    if ((b & 8'hFE) == 8'hC6) return C_RM_IMM;
    if ((b & 8'hF0) == 8'hB0) return C_REG_IMM;
    if ((b & 8'hFC) == 8'hA0) return C_ACC_MEM;
    if ((b & 8'hFD) == 8'h8C) return C_SEG_RM;
    if (b == 8'hFF) return C_GRP_FF;
    if ((b & 8'hF8) == 8'h50) return C_REG16;
    if ((b & 8'hE7) == 8'h06) return C_SEG;
    if ((b & 8'hF8) == 8'h58) return C_REG16;
    if ((b & 8'hE7) == 8'h07) return C_SEG;
    if (b == 8'h8F) return C_GRP_8F;
    if ((b & 8'hFE) == 8'h86) return C_RM_REG;
    if ((b & 8'hF8) == 8'h90) return C_REG16;
    if ((b & 8'hFC) == 8'h00 || (b & 8'hFC) == 8'h10) return C_RM_REG;
    if ((b & 8'hFE) == 8'h04 || (b & 8'hFE) == 8'h14) return C_ACC_IMM;
    if ((b & 8'hFC) == 8'h80) return C_RM_IMM;
    if ((b & 8'hFC) == 8'hE4) return C_PORT;
    if ((b & 8'hFC) == 8'hEC) return C_DXPORT;
    if (b == 8'h8D || (b & 8'hFE) == 8'hC4) return C_RM_REG;
    if (bare_known(b)) return C_BARE;
    return C_BAD;
  endfunction

  function automatic logic has_modrm(input cls_t c);
    return c == C_RM_REG || c == C_RM_IMM || c == C_SEG_RM ||
           c == C_GRP_FF || c == C_GRP_8F;
  endfunction

  function automatic logic [1:0] disp_len(input cls_t c, input logic [7:0] m);
    if (c == C_ACC_MEM) return 2'd2;
    if (!has_modrm(c)) return 2'd0;
    case (m[7:6])
      2'd0: return (m[2:0] == 3'd6) ? 2'd2 : 2'd0;
      2'd1: return 2'd1;
      2'd2: return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] imm_len(input cls_t c, input logic [7:0] op);
    case (c)
      C_RM_IMM: begin
        if ((op & 8'hFC) == 8'h80) return (!op[1] && op[0]) ? 2'd2 : 2'd1;
        return op[0] ? 2'd2 : 2'd1;
      end
      C_REG_IMM: return op[3] ? 2'd2 : 2'd1;
      C_ACC_IMM: return op[0] ? 2'd2 : 2'd1;
      C_PORT:    return 2'd1;
      default:   return 2'd0;
    endcase
  endfunction

  function automatic logic group_ok(input logic [7:0] op, input logic [7:0] m);
    if (op == 8'hFF) return m[5:3] == 3'd6;
    if (op == 8'h8F) return m[5:3] == 3'd0;
    if ((op & 8'hFC) == 8'h80) return m[5:3] == 3'd0 || m[5:3] == 3'd2;
    return 1'b1;
  endfunction

endpackage

// ----- hdl/i86d_stream_if.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// i86d_stream_if
// Valid/ready channel carrying one payload per transaction.
// -----------------------------------------------------------------------------
interface i86d_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hdl/instr_decoder_8086_subset.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// instr_decoder_8086_subset
// 8086 subset decoder: code bytes in, one operand record per instruction out.
// -----------------------------------------------------------------------------
// Usage:
//   in_ch  carries {code_byte, stream_end}; one byte per transaction.
//   out_ch carries one rec_t per finished instruction, error or truncation.
//   Each byte advances a one-hot phase machine
//   (opcode, ModRM, displacement lo/hi, immediate lo/hi). The byte that
//   completes an instruction produces its record in the output register
//   in the cycle after acceptance. Throughput is one byte per cycle, set by
//   the phase machine step, while the receiver does not stall.
//   An error record halts decoding; bytes are dropped until stream_end.
//   A stream_end byte inside an instruction yields a truncated record.
//   Synchronous active-low reset returns to the opcode phase, unhalted, with
//   the output register empty.
//   When the receiver stalls, the output register holds its record and no
//   new byte is taken until that record leaves (it may leave in the same
//   cycle the byte enters).
// -----------------------------------------------------------------------------
module instr_decoder_8086_subset import i86d_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  i86d_stream_if.sink   in_ch,
  i86d_stream_if.source out_ch
);

  logic  step, emit;
  gath_t gath;
  rec_t  rec;
  logic  out_valid_r, out_valid_nxt;
  rec_t  out_rec_r;

  // Byte may enter if the output slot is free now or drains this cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  i86d_collect u_collect (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .code_byte  (in_ch.data.code_byte),
    .stream_end (in_ch.data.stream_end),
    .emit       (emit),
    .gath       (gath)
  );

  assign step = in_ch.valid && in_ch.ready;

  i86d_build u_build (.g(gath), .rec(rec));

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
    if (emit) out_rec_r <= rec;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_rec_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !emit) else $error("record overwritten");
  a_emit_sets: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r) else $error("record lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_rec_r)) else $error("record changed");
endmodule

// ----- hdl/i86d_collect.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// i86d_collect
// Byte phase machine: gathers opcode, ModRM, displacement and immediate.
// -----------------------------------------------------------------------------
module i86d_collect import i86d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,        // byte accepted this cycle
  input  logic [7:0] code_byte,
  input  logic       stream_end,
  output logic       emit,        // a record follows from this byte
  output gath_t      gath
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  opc_r, opc_nxt, modrm_r, modrm_nxt;
  logic [15:0] disp_r, disp_nxt, imm_r, imm_nxt;
  logic [2:0]  len_r, len_nxt;
  logic        halt_r, halt_nxt;

  cls_t       c;
  logic [1:0] dl, il;
  logic       bad, done;
  phase_t     nx;

  always_comb begin
    phase_nxt = phase_r;
    opc_nxt   = opc_r;
    modrm_nxt = modrm_r;
    disp_nxt  = disp_r;
    imm_nxt   = imm_r;
    len_nxt   = len_r + 3'd1;
    halt_nxt  = halt_r;
    bad       = 1'b0;
    case (phase_r)
      PH_OPC: begin
        opc_nxt = code_byte; modrm_nxt = '0; disp_nxt = '0; imm_nxt = '0;
        len_nxt = 3'd1;
        bad = (classify(code_byte) == C_BAD);
      end
      PH_MODRM: begin
        modrm_nxt = code_byte;
        bad = !group_ok(opc_r, code_byte);
      end
      PH_DLO: begin
        disp_nxt = {8'h00, code_byte};
        if (disp_len(classify(opc_r), modrm_r) == 2'd1 && code_byte[7])
          disp_nxt[15:8] = 8'hFF;
      end
      PH_DHI: disp_nxt = {code_byte, disp_r[7:0]};
      PH_ILO: begin
        imm_nxt = {8'h00, code_byte};
        if ((opc_r & 8'hFC) == 8'h80 && opc_r[1] && code_byte[7])
          imm_nxt[15:8] = 8'hFF;
      end
      PH_IHI: imm_nxt = {code_byte, imm_r[7:0]};
      default: ;
    endcase
    c  = classify(opc_nxt);
    dl = disp_len(c, modrm_nxt);
    il = imm_len(c, opc_nxt);
    done = 1'b0;
    nx = PH_OPC;
    if (phase_r == PH_OPC && has_modrm(c)) nx = PH_MODRM;
    else if ((phase_r == PH_OPC || phase_r == PH_MODRM) && dl != 2'd0) nx = PH_DLO;
    else if (phase_r == PH_DLO && dl == 2'd2) nx = PH_DHI;
    else if ((phase_r == PH_OPC || phase_r == PH_MODRM || phase_r == PH_DLO ||
              phase_r == PH_DHI) && il != 2'd0) nx = PH_ILO;
    else if (phase_r == PH_ILO && il == 2'd2) nx = PH_IHI;
    else done = 1'b1;

    gath.opc = opc_nxt; gath.modrm = modrm_nxt; gath.disp = disp_nxt;
    gath.imm = imm_nxt; gath.len = len_nxt;
    if (bad) gath.status = ST_BAD;
    else if (done) gath.status = ST_OK;
    else gath.status = ST_TRUNC;
    emit = step && !halt_r && (bad || done || stream_end);

    if (halt_r) begin
      phase_nxt = phase_r;
      opc_nxt = opc_r; modrm_nxt = modrm_r; disp_nxt = disp_r; imm_nxt = imm_r;
      len_nxt = len_r;
      halt_nxt = !stream_end;
    end else if (bad) begin
      phase_nxt = PH_OPC;
      halt_nxt = !stream_end;
    end else if (done || stream_end) begin
      phase_nxt = PH_OPC;
    end else begin
      phase_nxt = nx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPC;
      halt_r  <= 1'b0;
      opc_r   <= '0;
      modrm_r <= '0;
      disp_r  <= '0;
      imm_r   <= '0;
      len_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      halt_r  <= halt_nxt;
      opc_r   <= opc_nxt;
      modrm_r <= modrm_nxt;
      disp_r  <= disp_nxt;
      imm_r   <= imm_nxt;
      len_r   <= len_nxt;
    end
  end

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(phase_r))
    else $error("phase not one-hot");
  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> phase_r == PH_OPC) else $error("halted mid-instruction");
  a_bad_halts: assert property (@(posedge clk) disable iff (!rst_n)
    emit && gath.status == ST_BAD && !stream_end |=> halt_r)
    else $error("error did not halt");
endmodule

// ----- hdl/i86d_build.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// i86d_build
// Turns a gathered instruction into its operand record.
// -----------------------------------------------------------------------------
module i86d_build import i86d_pkg::*; (
  input  gath_t g,
  output rec_t  rec
);

  cls_t       c;
  logic [7:0] op, m;
  logic [2:0] rmk, rmr, rg, rm;
  logic       d;
  logic [1:0] w;

  always_comb begin
    op = g.opc; m = g.modrm;
    c  = classify(op);
    rg = m[5:3]; rm = m[2:0];
    rmk = (m[7:6] == 2'd3) ? K_REG : ((m[7:6] == 2'd0 && rm == 3'd6) ? K_DIR : K_EA);
    rmr = (m[7:6] == 2'd3) ? rm : 3'd0;
    d = op[1]; w = {1'b0, op[0]};
    rec = '0;
    case (c)
      C_RM_REG: begin
        if ((op & 8'hFC) == 8'h88) rec.mnemonic = MN_MOV;
        else if ((op & 8'hFC) == 8'h00) rec.mnemonic = MN_ADD;
        else if ((op & 8'hFC) == 8'h10) rec.mnemonic = MN_ADC;
        else if ((op & 8'hFE) == 8'h86) rec.mnemonic = MN_XCHG;
        else if (op == 8'h8D) begin rec.mnemonic = MN_LEA; d = 1'b1; w = 2'd1; end
        else begin
          rec.mnemonic = op[0] ? MN_LDS : MN_LES; d = 1'b1; w = 2'd2;
        end
        if (d) begin
          rec.dest_kind = K_REG; rec.dest_reg = rg; rec.src_kind = rmk; rec.src_reg = rmr;
        end else begin
          rec.dest_kind = rmk; rec.dest_reg = rmr; rec.src_kind = K_REG; rec.src_reg = rg;
        end
      end
      C_RM_IMM: begin
        rec.mnemonic = ((op & 8'hFC) == 8'h80) ? ((rg == 3'd0) ? MN_ADD : MN_ADC) : MN_MOV;
        rec.dest_kind = rmk; rec.dest_reg = rmr; rec.src_kind = K_IMM;
      end
      C_REG_IMM: begin
        rec.dest_kind = K_REG; rec.dest_reg = op[2:0]; rec.src_kind = K_IMM;
        w = {1'b0, op[3]};
      end
      C_ACC_MEM: begin
        rec.dest_kind = d ? K_DIR : K_REG; rec.src_kind = d ? K_REG : K_DIR;
      end
      C_SEG_RM: begin
        w = 2'd1;
        if (d) begin
          rec.dest_kind = K_SEG; rec.dest_reg = {1'b0, rg[1:0]};
          rec.src_kind = rmk; rec.src_reg = rmr;
        end else begin
          rec.dest_kind = rmk; rec.dest_reg = rmr;
          rec.src_kind = K_SEG; rec.src_reg = {1'b0, rg[1:0]};
        end
      end
      C_GRP_FF, C_GRP_8F: begin
        rec.mnemonic = (c == C_GRP_FF) ? MN_PUSH : MN_POP;
        rec.dest_kind = rmk; rec.dest_reg = rmr; w = 2'd1;
      end
      C_REG16: begin
        w = 2'd1;
        rec.dest_kind = K_REG;
        if ((op & 8'hF8) == 8'h90) begin
          rec.mnemonic = MN_XCHG; rec.src_kind = K_REG; rec.src_reg = op[2:0];
        end else begin
          rec.mnemonic = ((op & 8'hF8) == 8'h50) ? MN_PUSH : MN_POP;
          rec.dest_reg = op[2:0];
        end
      end
      C_SEG: begin
        rec.mnemonic = op[0] ? MN_POP : MN_PUSH;
        rec.dest_kind = K_SEG; rec.dest_reg = {1'b0, op[4:3]}; w = 2'd1;
      end
      C_ACC_IMM: begin
        rec.mnemonic = (op[7:4] == 4'h0) ? MN_ADD : MN_ADC;
        rec.dest_kind = K_REG; rec.src_kind = K_IMM;
      end
      C_PORT, C_DXPORT: begin
        rec.mnemonic = d ? MN_OUT : MN_IN;
        rec.dest_kind = d ? ((c == C_PORT) ? K_PORT : K_DX) : K_REG;
        rec.src_kind  = d ? K_REG : ((c == C_PORT) ? K_PORT : K_DX);
      end
      default: begin
        rec.mnemonic = bare_mn(op); w = 2'd0;
      end
    endcase
    rec.op_width = w;
    rec.ea_rm = (rec.dest_kind == K_EA || rec.src_kind == K_EA) ? rm : 3'd0;
    rec.disp_size = disp_len(c, m);
    rec.displacement = g.disp;
    rec.immediate = g.imm;
    rec.inst_length = g.len;
    if (g.status != ST_OK) begin
      rec = '0;
      rec.status = g.status;
      rec.inst_length = g.len;
    end
  end
endmodule
